// ===== rtl/cdt_pkg.sv =====
// Shared types, codes and field layout for the countdown timer table.
`default_nettype none

package cdt_pkg;

  // Table geometry
  localparam int SLOTS      = 16;
  localparam int COUNT_BITS = 16;
  localparam int SIDX       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CMP_W      = (SIDX > 4) ? SIDX : 4;

  // Field widths
  localparam int CMD_W   = 2;
  localparam int DELAY_W = 16;
  localparam int TAG_W   = 32;
  localparam int SLOT_W  = 4;
  localparam int KIND_W  = 3;

  // Input data word, lowest bit first: delay, tag, slot (cmd travels in tuser)
  localparam int IN_RAW_W    = DELAY_W + TAG_W + SLOT_W;
  localparam int IN_TDATA_W  = ((IN_RAW_W + 7) / 8) * 8;
  // Output data word, lowest bit first: slot, tag (kind travels in tuser)
  localparam int OUT_RAW_W   = SLOT_W + TAG_W;
  localparam int OUT_TDATA_W = ((OUT_RAW_W + 7) / 8) * 8;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // Commands
  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CANCEL = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_ADDED     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FULL      = 3'd1;
  localparam logic [KIND_W-1:0] KIND_CANCELLED = 3'd2;
  localparam logic [KIND_W-1:0] KIND_NOT_FOUND = 3'd3;
  localparam logic [KIND_W-1:0] KIND_FIRED     = 3'd4;
  localparam logic [KIND_W-1:0] KIND_IDLE      = 3'd5;

  // One timer entry as it travels around the ring
  typedef struct packed {
    logic                  pending;
    logic [COUNT_BITS-1:0] rem;
    logic [TAG_W-1:0]      tag;
  } ent_t;

  // What the head unit did to the entry passing it
  typedef struct packed {
    logic             take;
    logic             hit;
    logic             fire;
    logic [TAG_W-1:0] tag;
  } head_res_t;

  // Clamp a requested delay to the counter range
  function automatic logic [COUNT_BITS-1:0] sat_delay(input logic [DELAY_W-1:0] delay);
    logic [31:0] d;
    d = 32'(delay);
    if (d > 32'(COUNT_MAX)) begin
      return COUNT_MAX;
    end
    return COUNT_BITS'(d);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/countdown_timer_table_core.sv =====
// Countdown timer table: top level with ring sequencer and output register.
//
// Usage:
//   Input words arrive on s_tvalid/s_tready with the command in s_tuser and
//   its operands in s_tdata: add a timer (delay, tag), cancel a slot, or
//   advance all timers one tick.
//   Results leave on m_tvalid/m_tready with the result kind in m_tuser, slot
//   and tag in m_tdata, and m_tlast set on the final result of each command.
//   Add and cancel give one result; a tick gives one result per fired timer
//   in ascending slot order, or one idle result.
//   The timers sit in a ring of SLOTS cells that rotates one place a cycle
//   unless the output stalls; every add, cancel or tick makes one full turn
//   past the head unit. The final result is registered in the finish state
//   that follows the turn (fired results may show during it). The ring turn
//   sets the rate; one word is worked on at a time and s_tready is high only
//   between commands. The unused command code gives no result and makes no
//   turn. When the receiver stalls, the ring holds in place until the output
//   register frees up, and no result is lost.
//   Reset (rst, synchronous) empties the table and drops any result in
//   flight.
`default_nettype none

module countdown_timer_table_core
  import cdt_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  // delay[15:0], tag[47:16], slot[51:48], zero fill above
  input  wire logic [IN_TDATA_W-1:0]  s_tdata,
  // cmd[1:0]
  input  wire logic [CMD_W-1:0]       s_tuser,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  // slot_out[3:0], tag_out[35:4], zero fill above
  output logic [OUT_TDATA_W-1:0]      m_tdata,
  // kind[2:0]
  output logic [KIND_W-1:0]           m_tuser,
  output logic                        m_tvalid,
  output logic                        m_tlast,
  input  wire logic                   m_tready
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SWEEP  = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0]         state;
  logic [CMD_W-1:0]   cmd;
  logic [DELAY_W-1:0] delay;
  logic [TAG_W-1:0]   tag;
  logic [SLOT_W-1:0]  slot;
  logic [SIDX-1:0]    step;
  logic               found;
  logic [SIDX-1:0]    found_slot;
  logic               held_valid;
  logic [SIDX-1:0]    held_slot;
  logic [TAG_W-1:0]   held_tag;

  logic [KIND_W-1:0]  o_kind;
  logic [SLOT_W-1:0]  o_slot;
  logic [TAG_W-1:0]   o_tag;
  logic               o_last;
  logic               o_valid;

  logic [KIND_W-1:0]  o_kind_next;
  logic [SLOT_W-1:0]  o_slot_next;
  logic [TAG_W-1:0]   o_tag_next;
  logic               o_last_next;
  logic               out_load;
  logic               out_free;
  logic               advance;
  logic               shift;
  logic               in_acc;

  ent_t               ring [SLOTS];
  ent_t               head_out;
  head_res_t          head_res;

  assign in_acc   = s_tvalid && s_tready;
  assign s_tready = (state == ST_IDLE);
  assign out_free = !o_valid || m_tready;
  assign advance  = !(head_res.fire && held_valid) || out_free;
  assign shift    = (state == ST_SWEEP) && advance;

  // Ring of slot cells rotating toward the head
  for (genvar k = 0; k < SLOTS; k++) begin : g_cell
    if (k == SLOTS - 1) begin : g_tail
      cdt_cell u_cell (.clk(clk), .rst(rst), .shift(shift), .d(head_out), .q(ring[k]));
    end else begin : g_mid
      cdt_cell u_cell (.clk(clk), .rst(rst), .shift(shift), .d(ring[k+1]), .q(ring[k]));
    end
  end

  cdt_head u_head (
    .cmd     (cmd),
    .delay   (delay),
    .tag     (tag),
    .slot    (slot),
    .step    (step),
    .found   (found),
    .ent_in  (ring[0]),
    .ent_out (head_out),
    .res     (head_res)
  );

  // Sequencer: latch command, turn the ring once for a valid command, then finish
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      step       <= '0;
      found      <= 1'b0;
      held_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            step       <= '0;
            found      <= 1'b0;
            held_valid <= 1'b0;
            if (s_tuser == CMD_ADD || s_tuser == CMD_CANCEL || s_tuser == CMD_TICK) begin
              state <= ST_SWEEP;
            end
          end
        end
        ST_SWEEP: begin
          if (advance) begin
            if (head_res.take || head_res.hit) begin
              found <= 1'b1;
            end
            if (head_res.fire) begin
              held_valid <= 1'b1;
            end
            step <= step + SIDX'(1);
            if (step == SIDX'(SLOTS - 1)) begin
              state <= ST_FINISH;
            end
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Command fields and sweep bookkeeping
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd   <= s_tuser;
      delay <= s_tdata[15:0];
      tag   <= s_tdata[47:16];
      slot  <= s_tdata[51:48];
    end
    if (shift && head_res.take) begin
      found_slot <= step;
    end
    if (shift && head_res.fire) begin
      held_slot <= step;
      held_tag  <= head_res.tag;
    end
  end

  // Select the next result word
  always_comb begin
    out_load    = 1'b0;
    o_kind_next = KIND_IDLE;
    o_slot_next = '0;
    o_tag_next  = '0;
    o_last_next = 1'b1;
    case (state)
      ST_SWEEP: begin
        // A new fire pushes out the one held before it
        if (head_res.fire && held_valid && out_free) begin
          out_load    = 1'b1;
          o_kind_next = KIND_FIRED;
          o_slot_next = SLOT_W'(held_slot);
          o_tag_next  = held_tag;
          o_last_next = 1'b0;
        end
      end
      ST_FINISH: begin
        out_load = out_free;
        case (cmd)
          CMD_ADD: begin
            o_kind_next = found ? KIND_ADDED : KIND_FULL;
            o_slot_next = found ? SLOT_W'(found_slot) : '0;
          end
          CMD_CANCEL: begin
            o_kind_next = found ? KIND_CANCELLED : KIND_NOT_FOUND;
            o_slot_next = slot;
          end
          CMD_TICK: begin
            if (held_valid) begin
              o_kind_next = KIND_FIRED;
              o_slot_next = SLOT_W'(held_slot);
              o_tag_next  = held_tag;
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (out_load) begin
      o_valid <= 1'b1;
    end else if (m_tready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      o_kind <= o_kind_next;
      o_slot <= o_slot_next;
      o_tag  <= o_tag_next;
      o_last <= o_last_next;
    end
  end

  assign m_tvalid = o_valid;
  assign m_tlast  = o_last;
  assign m_tuser  = o_kind;
  assign m_tdata  = OUT_TDATA_W'({o_tag, o_slot});

  // Never overwrite a result the receiver has not taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!o_valid || m_tready))
    else $error("result register overwritten");

  // Only a tick may fire timers
  a_fire_on_tick: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SWEEP && head_res.fire) |-> (cmd == CMD_TICK))
    else $error("timer fired outside a tick");

  // An add claims at most one slot per sweep
  a_single_take: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SWEEP && head_res.take) |-> !found)
    else $error("add claimed a second slot");

  // The finish step only follows a ring turn
  a_finish_order: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && $past(state) != ST_FINISH) |-> ($past(state) == ST_SWEEP))
    else $error("finish reached without a sweep");

endmodule

`default_nettype wire

// ===== rtl/cdt_cell.sv =====
// One slot of the rotating timer ring.
`default_nettype none

module cdt_cell
  import cdt_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic shift,
  input  wire ent_t d,
  output ent_t      q
);

  logic                  pending;
  logic [COUNT_BITS-1:0] rem;
  logic [TAG_W-1:0]      tag;

  // Pending flag is control state and clears on reset
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b0;
    end else if (shift) begin
      pending <= d.pending;
    end
  end

  // Count and tag are only meaningful while pending
  always_ff @(posedge clk) begin
    if (shift) begin
      rem <= d.rem;
      tag <= d.tag;
    end
  end

  assign q = '{pending: pending, rem: rem, tag: tag};

endmodule

`default_nettype wire

// ===== rtl/cdt_head.sv =====
// Head unit: applies the current command to the entry leaving the ring.
`default_nettype none

module cdt_head
  import cdt_pkg::*;
(
  input  wire logic [CMD_W-1:0]   cmd,
  input  wire logic [DELAY_W-1:0] delay,
  input  wire logic [TAG_W-1:0]   tag,
  input  wire logic [SLOT_W-1:0]  slot,
  input  wire logic [SIDX-1:0]    step,
  input  wire logic               found,
  input  wire ent_t               ent_in,
  output ent_t                    ent_out,
  output head_res_t               res
);

  always_comb begin
    ent_out = ent_in;
    res     = '0;
    case (cmd)
      CMD_ADD: begin
        // Claim the first free slot seen in this sweep
        if (!ent_in.pending && !found) begin
          ent_out.pending = 1'b1;
          ent_out.rem     = sat_delay(delay);
          ent_out.tag     = tag;
          res.take        = 1'b1;
        end
      end
      CMD_CANCEL: begin
        // Free the addressed slot if it holds a timer
        if (ent_in.pending && (CMP_W'(step) == CMP_W'(slot))) begin
          ent_out.pending = 1'b0;
          res.hit         = 1'b1;
        end
      end
      CMD_TICK: begin
        // Fire at count one or zero, otherwise count down
        if (ent_in.pending) begin
          if (ent_in.rem[COUNT_BITS-1:1] == '0) begin
            ent_out.pending = 1'b0;
            res.fire        = 1'b1;
            res.tag         = ent_in.tag;
          end else begin
            ent_out.rem = ent_in.rem - COUNT_BITS'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== tb/countdown_timer_table_core_tb.sv =====
// Self-checking testbench for the countdown timer table: directed and random words, scoreboard.
`timescale 1ns / 100ps

module countdown_timer_table_core_tb
  import cdt_pkg::*;
;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int STUCK_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 40;

  // One result word as the block should send it
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SLOT_W-1:0] slot;
    logic [TAG_W-1:0]  tag;
    logic              last;
  } timer_result_t;

  // Shadow timer table plus the queue of results still owed by the block
  class timer_scoreboard;
    logic                  armed[SLOTS];
    logic [COUNT_BITS-1:0] count_left[SLOTS];
    logic [TAG_W-1:0]      stored_tag[SLOTS];
    timer_result_t         due_q[$];
    int                    mismatches;
    int                    checked;
    int                    cmd_seen[4];
    int                    kind_seen[8];

    function new();
      foreach (armed[i]) armed[i] = 1'b0;
      foreach (cmd_seen[i]) cmd_seen[i] = 0;
      foreach (kind_seen[i]) kind_seen[i] = 0;
      mismatches = 0;
      checked = 0;
    endfunction

    function void queue_result(logic [KIND_W-1:0] kind, logic [SLOT_W-1:0] slot,
                               logic [TAG_W-1:0] tag, logic last);
      timer_result_t r;
      r.kind = kind;
      r.slot = slot;
      r.tag  = tag;
      r.last = last;
      due_q.push_back(r);
    endfunction

    // Apply one accepted command word to the shadow table
    function void note_input(logic [CMD_W-1:0] cmd, logic [DELAY_W-1:0] delay,
                             logic [TAG_W-1:0] tag, logic [SLOT_W-1:0] slot);
      int               free_idx;
      int               top;
      logic [SLOTS-1:0] fire_mask;
      cmd_seen[cmd]++;
      case (cmd)
        CMD_ADD: begin
          free_idx = -1;
          for (int i = SLOTS - 1; i >= 0; i--) if (!armed[i]) free_idx = i;
          if (free_idx < 0) begin
            queue_result(KIND_FULL, '0, '0, 1'b1);
          end else begin
            armed[free_idx]      = 1'b1;
            count_left[free_idx] = (32'(delay) > 32'(COUNT_MAX)) ? COUNT_MAX
                                                                 : COUNT_BITS'(delay);
            stored_tag[free_idx] = tag;
            queue_result(KIND_ADDED, SLOT_W'(free_idx), '0, 1'b1);
          end
        end
        CMD_CANCEL: begin
          if (int'(slot) < SLOTS && armed[slot]) begin
            armed[slot] = 1'b0;
            queue_result(KIND_CANCELLED, slot, '0, 1'b1);
          end else begin
            queue_result(KIND_NOT_FOUND, slot, '0, 1'b1);
          end
        end
        CMD_TICK: begin
          // find what fires and count the rest down, then emit in slot order
          fire_mask = '0;
          top = -1;
          for (int i = 0; i < SLOTS; i++) begin
            if (armed[i]) begin
              if (count_left[i] <= 1) begin
                fire_mask[i] = 1'b1;
                top = i;
              end else begin
                count_left[i] = count_left[i] - 1'b1;
              end
            end
          end
          if (top < 0) begin
            queue_result(KIND_IDLE, '0, '0, 1'b1);
          end else begin
            for (int i = 0; i < SLOTS; i++) begin
              if (fire_mask[i]) begin
                armed[i] = 1'b0;
                queue_result(KIND_FIRED, SLOT_W'(i), stored_tag[i], i == top);
              end
            end
          end
        end
        default: ;
      endcase
    endfunction

    // Compare one accepted result word with the oldest one owed
    function void check_result(logic [KIND_W-1:0] kind, logic [SLOT_W-1:0] slot,
                               logic [TAG_W-1:0] tag, logic last);
      timer_result_t want;
      kind_seen[kind]++;
      checked++;
      if (due_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result kind %0d slot %0d tag %h last %b",
                   $time, kind, slot, tag, last);
        return;
      end
      want = due_q.pop_front();
      if (want.kind !== kind || want.slot !== slot || want.tag !== tag ||
          want.last !== last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch, expected kind %0d slot %0d tag %h last %b, %s",
                   $time, want.kind, want.slot, want.tag, want.last,
                   $sformatf("got kind %0d slot %0d tag %h last %b",
                             kind, slot, tag, last));
      end
    endfunction

    function int outstanding();
      return due_q.size();
    endfunction

    // Any result still owed at the end is a failure
    function void flush_leftovers();
      if (due_q.size() != 0) begin
        $display("%0d results never arrived", due_q.size());
        mismatches += due_q.size();
        due_q.delete();
      end
    endfunction

    function int pick_armed();
      int cand[$];
      for (int i = 0; i < SLOTS; i++) if (armed[i]) cand.push_back(i);
      if (cand.size() == 0) return -1;
      return cand[$urandom_range(cand.size() - 1)];
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic [CMD_W-1:0]       s_tuser;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [KIND_W-1:0]      m_tuser;
  logic                   m_tvalid;
  logic                   m_tlast;
  logic                   m_tready;

  timer_scoreboard sb;
  bit calm;
  bit hold_req;
  int hold_left;
  int stuck_cycles;

  countdown_timer_table_core DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tvalid (m_tvalid),
    .m_tlast  (m_tlast),
    .m_tready (m_tready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watch both handshakes at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready)
        sb.check_result(m_tuser, m_tdata[SLOT_W-1:0], m_tdata[SLOT_W +: TAG_W], m_tlast);
      if (s_tvalid && s_tready)
        sb.note_input(s_tuser, s_tdata[DELAY_W-1:0], s_tdata[DELAY_W +: TAG_W],
                      s_tdata[DELAY_W+TAG_W +: SLOT_W]);
    end
  end

  // End the run if no word moves for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", stuck_cycles);
        $display("countdown_timer_table_core_tb: errors");
        $finish;
      end
    end
  end

  // Result side: random back-pressure, calm stretches and one long hold-off
  initial begin
    m_tready = 1'b0;
    hold_left = 0;
    @(negedge rst);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (calm) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= ($urandom_range(99) >= 20);
      end
    end
  end

  // Offer one command word and hold it until accepted
  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [DELAY_W-1:0] delay,
                           input logic [TAG_W-1:0] tag, input logic [SLOT_W-1:0] slot);
    int gap;
    gap = 0;
    if (!calm) while ($urandom_range(99) < 20) gap++;
    repeat (gap) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tuser  <= cmd;
    s_tdata  <= IN_TDATA_W'({slot, tag, delay});
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
  endtask

  // Stop offering and wait until every owed result has come back
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.outstanding() > 0) @(posedge clk);
  endtask

  // Mostly realistic timer traffic: short delays, cancels of live slots, ticks
  task automatic random_words(input int count);
    logic [CMD_W-1:0]   cmd;
    logic [DELAY_W-1:0] delay;
    logic [TAG_W-1:0]   tag;
    logic [SLOT_W-1:0]  slot;
    int                 r;
    int                 live;
    repeat (count) begin
      delay = DELAY_W'($urandom);
      tag   = $urandom;
      slot  = SLOT_W'($urandom);
      r = $urandom_range(99);
      if (r < 40) begin
        cmd = CMD_ADD;
        r = $urandom_range(99);
        if (r < 70) delay = DELAY_W'($urandom_range(5));
        else if (r < 90) delay = DELAY_W'($urandom_range(40, 6));
      end else if (r < 60) begin
        cmd = CMD_CANCEL;
        live = sb.pick_armed();
        if (live >= 0 && $urandom_range(99) < 75) slot = SLOT_W'(live);
      end else if (r < 95) begin
        cmd = CMD_TICK;
      end else begin
        cmd = CMD_UNUSED;
      end
      send_word(cmd, delay, tag, slot);
    end
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    calm = 1'b0;
    hold_req = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty table, field extremes, ignored command, full table, full tick
    send_word(CMD_TICK, 16'hFFFF, 32'h0, 4'h0);
    send_word(CMD_CANCEL, 16'h0, 32'hFFFF_FFFF, 4'hF);
    send_word(CMD_ADD, 16'd0, 32'h0000_0000, 4'h0);
    send_word(CMD_ADD, 16'd1, 32'hFFFF_FFFF, 4'hF);
    send_word(CMD_ADD, 16'hFFFF, 32'hA5A5_A5A5, 4'h5);
    send_word(CMD_ADD, 16'd2, 32'h5A5A_5A5A, 4'hA);
    send_word(CMD_UNUSED, DELAY_W'($urandom), $urandom, SLOT_W'($urandom));
    send_word(CMD_TICK, 16'h0, 32'h0, 4'h0);
    send_word(CMD_CANCEL, 16'h0, 32'h0, 4'd2);
    send_word(CMD_CANCEL, 16'hFFFF, 32'h0, 4'd2);
    for (int n = 0; n < SLOTS - 1; n++)
      send_word(CMD_ADD, DELAY_W'(n % 2), 32'h1000_0000 + 32'(n), SLOT_W'(n));
    send_word(CMD_ADD, 16'd7, 32'hDEAD_BEEF, 4'h0);
    send_word(CMD_TICK, 16'h0, 32'h0, 4'h0);

    // Random traffic with idling on both sides, then a calm stretch
    random_words(90);
    calm = 1'b1;
    random_words(50);
    calm = 1'b0;

    // Result side holds off while words keep coming; then pause until all are back
    drain();
    hold_req = 1'b1;
    random_words(30);
    drain();
    random_words(60);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    sb.flush_leftovers();

    $display("covered %0d adds, %0d cancels, %0d ticks, %0d unused words; %0d results checked",
             sb.cmd_seen[CMD_ADD], sb.cmd_seen[CMD_CANCEL], sb.cmd_seen[CMD_TICK],
             sb.cmd_seen[CMD_UNUSED], sb.checked);
    $display("saw %0d fired, %0d table full, %0d cancelled, %0d not found, %0d idle ticks",
             sb.kind_seen[KIND_FIRED], sb.kind_seen[KIND_FULL], sb.kind_seen[KIND_CANCELLED],
             sb.kind_seen[KIND_NOT_FOUND], sb.kind_seen[KIND_IDLE]);
    if (sb.mismatches == 0) begin
      $display("countdown_timer_table_core_tb: clean");
    end else begin
      $display("countdown_timer_table_core_tb: errors");
    end
    $finish;
  end

endmodule
